>>> hdl/bns_pkg.sv
`timescale 1ns / 1ps

package bns_pkg;

  localparam int MAX_NODES_DEF  = 64;
  localparam int MAX_DEGREE_DEF = 6;

  localparam int STATE_W  = 64;
  localparam int LINK_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [2:0] MODE_LINK   = 3'd0;
  localparam logic [2:0] MODE_STATE  = 3'd1;
  localparam logic [2:0] MODE_SNAP   = 3'd2;
  localparam logic [2:0] MODE_STEP   = 3'd3;
  localparam logic [2:0] MODE_SEARCH = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TRUTH_TABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_DEGREE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS   = 2'd3;

  typedef struct packed {
    logic [2:0]        mode;
    logic [5:0]        node_index;
    logic [2:0]        link_slot;
    logic [LINK_W-1:0] link_source;
    logic              state_bit;
  } in_word_t;

  typedef struct packed {
    logic               matched;
    logic [15:0]        steps_taken;
    logic [STATE_W-1:0] node_states;
  } out_word_t;

endpackage

>>> hdl/bns_link_ram.sv
`timescale 1ns / 1ps

module bns_link_ram #(
  parameter int DEPTH = 384,
  parameter int AW    = 9
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [bns_pkg::LINK_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [bns_pkg::LINK_W-1:0] rd_data
);
  import bns_pkg::*;

  logic [LINK_W-1:0] mem [DEPTH];
  logic [LINK_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/boolean_network_step.sv
`timescale 1ns / 1ps
// Write link / write state / snapshot / unused modes (and search with max_steps 0): via S_REPORT.
// Step: S_ISSUE (one link read per cycle from the link RAM over all in-use nodes and slots),
// S_DRAIN, S_COMMIT, S_REPORT. Search: steps repeat until a snapshot match or max_steps steps.
// One word in flight at a time; busy stays high until its result strobe. Results cannot be stalled.
// Reset (synchronous, rst_n low): states and snapshot cleared, registers to defaults,
// link table contents undefined until written.
module boolean_network_step #(
  parameter int MAX_NODES  = bns_pkg::MAX_NODES_DEF,
  parameter int MAX_DEGREE = bns_pkg::MAX_DEGREE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  bns_pkg::in_word_t              in_data,
  output logic                           out_valid,
  output bns_pkg::out_word_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bns_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bns_pkg::*;

  localparam int DEPTH = MAX_NODES * MAX_DEGREE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ISSUE  = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_REPORT = 3'd4;

  // configuration
  logic [63:0] tt_r;
  logic [6:0]  ncnt_r;
  logic [2:0]  deg_r;
  logic [15:0] maxs_r;

  logic [6:0]  n_use;
  logic [2:0]  k_use;
  logic [STATE_W-1:0] use_mask;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  mode_r;
  logic [STATE_W-1:0] cur_r, snap_r, next_r;
  logic [15:0] steps_r;

  logic [NW-1:0] rd_node_r;
  logic [2:0]    rd_slot_r;
  logic [AW-1:0] base_r;

  logic          p_valid_r, p_first_r, p_last_r;
  logic [NW-1:0] p_node_r;
  logic [5:0]    idx_r, idx_nxt;

  logic          out_valid_r;
  out_word_t     out_data_r;

  logic          accept;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [LINK_W-1:0] rd_data;
  logic          src_bit;
  logic          slot_last, node_last;
  logic          next_match, limit_hit;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (ncnt_r == 7'd0) begin
      n_use = 7'd1;
    end else if (ncnt_r > 7'(MAX_NODES)) begin
      n_use = 7'(MAX_NODES);
    end else begin
      n_use = ncnt_r;
    end
    if (deg_r == 3'd0) begin
      k_use = 3'd1;
    end else if (deg_r > 3'(MAX_DEGREE)) begin
      k_use = 3'(MAX_DEGREE);
    end else begin
      k_use = deg_r;
    end
  end

  assign use_mask = ~({STATE_W{1'b1}} << n_use);

  // link RAM ports
  assign wr_en = accept && (in_data.mode == MODE_LINK)
                 && ({1'b0, in_data.node_index} < 7'(MAX_NODES))
                 && (in_data.link_slot < 3'(MAX_DEGREE));
  assign wr_addr = AW'(32'(in_data.node_index) * MAX_DEGREE + 32'(in_data.link_slot));
  assign rd_en   = (state_r == S_ISSUE);
  assign rd_addr = AW'(base_r + AW'(rd_slot_r));

  bns_link_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.link_source),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared lookup unit: one source bit per cycle shifted into the table index
  assign src_bit = ({1'b0, rd_data} < 7'(MAX_NODES)) ? cur_r[rd_data] : 1'b0;
  assign idx_nxt = p_first_r ? {5'd0, src_bit} : {idx_r[4:0], src_bit};

  assign slot_last  = (rd_slot_r == k_use - 3'd1);
  assign node_last  = (7'(rd_node_r) == n_use - 7'd1);
  assign next_match = (((next_r ^ snap_r) & use_mask) == '0);
  assign limit_hit  = ((17'(steps_r) + 17'd1) == 17'(maxs_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.mode == MODE_STEP) begin
            state_nxt = S_ISSUE;
          end else if (in_data.mode == MODE_SEARCH && maxs_r != 16'd0) begin
            state_nxt = S_ISSUE;
          end else begin
            state_nxt = S_REPORT;
          end
        end
      end
      S_ISSUE: begin
        if (slot_last && node_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_COMMIT;
      S_COMMIT: begin
        if (mode_r == MODE_STEP || next_match || limit_hit) begin
          state_nxt = S_REPORT;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_REPORT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control and state vectors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p_valid_r   <= 1'b0;
      tt_r        <= '0;
      ncnt_r      <= 7'd64;
      deg_r       <= 3'd2;
      maxs_r      <= 16'd1024;
      cur_r       <= '0;
      snap_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_REPORT);
      p_valid_r   <= (state_r == S_ISSUE);

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TRUTH_TABLE: tt_r   <= cfg_data;
          CFG_NODE_COUNT:  ncnt_r <= cfg_data[6:0];
          CFG_IN_DEGREE:   deg_r  <= cfg_data[2:0];
          CFG_MAX_STEPS:   maxs_r <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (accept) begin
        if (in_data.mode == MODE_STATE && {1'b0, in_data.node_index} < 7'(MAX_NODES)) begin
          cur_r[in_data.node_index] <= in_data.state_bit;
        end
        if (in_data.mode == MODE_SNAP) begin
          snap_r <= cur_r;
        end
      end

      if (state_r == S_COMMIT) begin
        cur_r <= next_r;
      end
    end
  end

  // sequencer counters and datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_data.mode;
      steps_r <= 16'd0;
      next_r  <= cur_r;
    end

    if (state_r == S_IDLE || state_r == S_COMMIT) begin
      rd_node_r <= '0;
      rd_slot_r <= 3'd0;
      base_r    <= '0;
    end else if (state_r == S_ISSUE) begin
      p_node_r  <= rd_node_r;
      p_first_r <= (rd_slot_r == 3'd0);
      p_last_r  <= slot_last;
      if (slot_last) begin
        rd_slot_r <= 3'd0;
        rd_node_r <= NW'(rd_node_r + NW'(1));
        base_r    <= AW'(base_r + AW'(MAX_DEGREE));
      end else begin
        rd_slot_r <= rd_slot_r + 3'd1;
      end
    end

    if (p_valid_r) begin
      idx_r <= idx_nxt;
      if (p_last_r) begin
        next_r[p_node_r] <= tt_r[idx_nxt];
      end
    end

    if (state_r == S_COMMIT) begin
      steps_r <= steps_r + 16'd1;
    end

    if (state_r == S_REPORT) begin
      out_data_r.matched     <= (((cur_r ^ snap_r) & use_mask) == '0);
      out_data_r.steps_taken <= steps_r;
      out_data_r.node_states <= cur_r;
    end
  end

endmodule
